// File: hw/rtl/round_robin_handoff_lock_assert.svh
// Assertion macros for the checker file of the handoff lock.
`ifndef ROUND_ROBIN_HANDOFF_LOCK_ASSERT_SVH
`define ROUND_ROBIN_HANDOFF_LOCK_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RRHL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RRHL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rrhl_pkg.sv
// Package with the widths, codes and control types of the handoff lock.
`default_nettype none
package rrhl_pkg;

    localparam int MAX_THREADS = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int LIST_W      = 7;
    localparam int ID_W        = 8;
    localparam int OP_W        = 2;
    localparam int ST_W        = 3;

    localparam logic [OP_W-1:0] OP_LOCK    = 2'd0;
    localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd2;

    localparam logic [ST_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [ST_W-1:0] ST_WAITING   = 3'd1;
    localparam logic [ST_W-1:0] ST_BUSY      = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_OWNER = 3'd4;
    localparam logic [ST_W-1:0] ST_RELEASED  = 3'd5;

    localparam logic [LIST_W-1:0] LIST_SIZE_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic publish;
    } rrhl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } rrhl_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/rrhl_if.sv
// Request and response channel interfaces of the handoff lock.
`default_nettype none
interface rrhl_req_if;
    import rrhl_pkg::*;
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] thread_id;

    modport source (output valid, output operation, output thread_id, input ready);
    modport sink   (input valid, input operation, input thread_id, output ready);
endinterface

interface rrhl_rsp_if;
    import rrhl_pkg::*;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic             owner_valid;
    logic [IDX_W-1:0] owner_thread;
    logic             handed_off;

    modport source (output valid, output status, output owner_valid,
                    output owner_thread, output handed_off, input ready);
    modport sink   (input valid, input status, input owner_valid,
                    input owner_thread, input handed_off, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rrhl_ctrl.sv
// Controller state machine of the handoff lock.
`default_nettype none
module rrhl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rrhl_pkg::rrhl_cmd_t cmd,
    input  rrhl_pkg::rrhl_sts_t sts
);
    import rrhl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/rrhl_dp.sv
// Datapath of the handoff lock: lock state, waiting flags, scan cursor, result.
`default_nettype none
module rrhl_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rrhl_pkg::rrhl_cmd_t          cmd,
    output rrhl_pkg::rrhl_sts_t          sts,
    input  logic                         cfg_wr_en,
    input  logic [rrhl_pkg::LIST_W-1:0]  cfg_wr_data,
    input  logic [rrhl_pkg::OP_W-1:0]    in_operation,
    input  logic [rrhl_pkg::ID_W-1:0]    in_thread_id,
    output logic [rrhl_pkg::ST_W-1:0]    status,
    output logic                         owner_valid,
    output logic [rrhl_pkg::IDX_W-1:0]   owner_thread,
    output logic                         handed_off
);
    import rrhl_pkg::*;

    logic [LIST_W-1:0]      list_size_reg, list_size_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [IDX_W-1:0]       owner_reg, owner_next;
    logic                   present_reg, present_next;
    logic [CNT_W-1:0]       active_reg, active_next;
    logic [MAX_THREADS-1:0] flags_reg, flags_next;
    logic [IDX_W-1:0]       cand_reg, cand_next;
    logic [IDX_W-1:0]       remain_reg, remain_next;
    logic [ST_W-1:0]        status_reg, status_next;
    logic                   handed_reg, handed_next;
    logic [ST_W-1:0]        out_status_reg;
    logic                   out_owner_valid_reg;
    logic [IDX_W-1:0]       out_owner_reg;
    logic                   out_handed_reg;

    logic [CNT_W-1:0] usable;
    logic             id_ok;
    logic [IDX_W-1:0] id_idx;
    logic [CNT_W-1:0] id_plus;
    logic             owner_hit;
    logic [CNT_W-1:0] me_plus;
    logic [CNT_W-1:0] cand_plus;
    logic             flag_at_cand;

    always_comb
    begin
        usable = (list_size_reg > CNT_W'(MAX_THREADS)) ? CNT_W'(MAX_THREADS) : list_size_reg;
        id_ok        = id_reg < ID_W'(usable);
        id_idx       = id_reg[IDX_W-1:0];
        id_plus      = CNT_W'(id_idx) + CNT_W'(1);
        owner_hit    = present_reg && (id_reg == ID_W'(owner_reg));
        me_plus      = CNT_W'(owner_reg) + CNT_W'(1);
        cand_plus    = CNT_W'(cand_reg) + CNT_W'(1);
        flag_at_cand = flags_reg[cand_reg];
    end

    assign sts.need_scan = (op_reg == OP_UNLOCK) && owner_hit;
    assign sts.scan_done = (remain_reg == '0) || flag_at_cand;

    always_comb
    begin
        list_size_next = list_size_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        owner_next     = owner_reg;
        present_next   = present_reg;
        active_next    = active_reg;
        flags_next     = flags_reg;
        cand_next      = cand_reg;
        remain_next    = remain_reg;
        status_next    = status_reg;
        handed_next    = handed_reg;

        if (cfg_wr_en)
        begin
            list_size_next = cfg_wr_data;
        end

        if (cmd.load)
        begin
            op_next = in_operation;
            id_next = in_thread_id;
        end

        if (cmd.exec)
        begin
            handed_next = 1'b0;
            status_next = ST_NOT_OWNER;
            unique case (op_reg)
                OP_LOCK, OP_TRYLOCK:
                begin
                    if (!id_ok)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        if (active_reg < id_plus)
                        begin
                            active_next = id_plus;
                        end
                        if (op_reg == OP_LOCK)
                        begin
                            flags_next[id_idx] = 1'b1;
                        end
                        if (owner_hit || !present_reg)
                        begin
                            present_next = 1'b1;
                            owner_next   = id_idx;
                            status_next  = ST_GRANTED;
                        end
                        else
                        begin
                            status_next = (op_reg == OP_LOCK) ? ST_WAITING : ST_BUSY;
                        end
                    end
                end
                OP_UNLOCK:
                begin
                    if (owner_hit)
                    begin
                        // The owner always sits below the active count, so the
                        // first candidate wraps with a single compare.
                        flags_next[owner_reg] = 1'b0;
                        present_next = 1'b0;
                        owner_next   = '0;
                        status_next  = ST_RELEASED;
                        cand_next    = (me_plus == active_reg) ? '0 : me_plus[IDX_W-1:0];
                        remain_next  = IDX_W'(active_reg - CNT_W'(1));
                    end
                end
                default:
                begin
                    status_next = ST_NOT_OWNER;
                end
            endcase
        end

        if (cmd.step && (remain_reg != '0))
        begin
            if (flag_at_cand)
            begin
                present_next = 1'b1;
                owner_next   = cand_reg;
                handed_next  = 1'b1;
            end
            else
            begin
                cand_next   = (cand_plus == active_reg) ? '0 : cand_plus[IDX_W-1:0];
                remain_next = remain_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg <= LIST_SIZE_RESET;
            owner_reg     <= '0;
            present_reg   <= 1'b0;
            active_reg    <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            list_size_reg <= list_size_next;
            owner_reg     <= owner_next;
            present_reg   <= present_next;
            active_reg    <= active_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        cand_reg   <= cand_next;
        remain_reg <= remain_next;
        status_reg <= status_next;
        handed_reg <= handed_next;
        if (cmd.publish)
        begin
            out_status_reg      <= status_reg;
            out_owner_valid_reg <= present_reg;
            out_owner_reg       <= present_reg ? owner_reg : '0;
            out_handed_reg      <= handed_reg;
        end
    end

    assign status       = out_status_reg;
    assign owner_valid  = out_owner_valid_reg;
    assign owner_thread = out_owner_reg;
    assign handed_off   = out_handed_reg;

endmodule
`default_nettype wire

// File: hw/rtl/round_robin_handoff_lock.sv
// Top level of the round-robin handoff lock.
//
//   Channel  Direction  Beat contents
//   req      in         operation (lock, trylock, unlock), thread_id
//   rsp      out        status, owner_valid, owner_thread, handed_off
//   cfg      in         list_size, written by cfg_wr_en / cfg_wr_data
//
// A lock or trylock beat goes from acceptance to a result in the output
// register through accept, execute and publish. An unlock by the owner
// adds a round-robin scan of the waiting-flag candidates between execute and
// publish. The scan reads one flag per cycle through a single cursor. Reset
// clears the owner, the active count and all waiting flags at once, and
// list_size returns to 64. A stalled response only blocks the publish step;
// the next request beat is still accepted and worked on while the previous
// result waits in the output register.
`default_nettype none
module round_robin_handoff_lock (
    input  logic                         clk,
    input  logic                         rst_n,
    rrhl_req_if.sink                     req,
    rrhl_rsp_if.source                   rsp,
    input  logic                         cfg_wr_en,
    input  logic [rrhl_pkg::LIST_W-1:0]  cfg_wr_data
);
    import rrhl_pkg::*;

    // Commands from the controller and status back from the datapath are the
    // only link between the two halves.
    rrhl_cmd_t cmd;
    rrhl_sts_t sts;

    rrhl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the lock state, the waiting flags, the scan cursor
    // and the output register that carries the response payload.
    rrhl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_operation (req.operation),
        .in_thread_id (req.thread_id),
        .status       (rsp.status),
        .owner_valid  (rsp.owner_valid),
        .owner_thread (rsp.owner_thread),
        .handed_off   (rsp.handed_off)
    );

endmodule
`default_nettype wire

// File: hw/rtl/rrhl_checker.sv
// Port-level checker of the handoff lock and its bind to the top level.
`default_nettype none
`include "round_robin_handoff_lock_assert.svh"
module rrhl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [rrhl_pkg::ST_W-1:0]   rsp_status,
    input logic                        rsp_owner_valid,
    input logic [rrhl_pkg::IDX_W-1:0]  rsp_owner_thread,
    input logic                        rsp_handed_off
);
    import rrhl_pkg::*;

    `RRHL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_owner_thread) && $stable(rsp_handed_off), "response beat changed while stalled")
    `RRHL_ASSERT_NOW(a_no_owner_zero, clk, rst_n, rsp_valid && !rsp_owner_valid, rsp_owner_thread == '0, "owner_thread not zero without an owner")
    `RRHL_ASSERT_NOW(a_handoff_release, clk, rst_n, rsp_valid && rsp_handed_off, (rsp_status == ST_RELEASED) && rsp_owner_valid, "handoff without a release that leaves an owner")
    `RRHL_ASSERT_NOW(a_grant_owner, clk, rst_n, rsp_valid && (rsp_status == ST_GRANTED), rsp_owner_valid, "grant reported with no owner")
    `RRHL_ASSERT_NOW(a_status_code, clk, rst_n, rsp_valid, rsp_status <= ST_RELEASED, "undefined status code")

endmodule

bind round_robin_handoff_lock rrhl_checker u_rrhl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_owner_valid  (rsp.owner_valid),
    .rsp_owner_thread (rsp.owner_thread),
    .rsp_handed_off   (rsp.handed_off)
);
`default_nettype wire

// File: sim/round_robin_handoff_lock_tb.sv
// Self-checking testbench for the round-robin handoff lock, with its own lock predictor.
`timescale 1ns / 1ps

module round_robin_handoff_lock_tb;
    import rrhl_pkg::*;

    // The request channel carries four operation codes, but only three have a
    // meaning. The fourth must be answered as a refused unlock.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // The worst unlock scan visits every active slot but the owner's. The tail
    // wait after the last reply covers it with some margin.
    localparam int TAIL_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PRINT_LIMIT  = 100;

    // One reply beat as the lock reports it.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             owner_valid;
        logic [IDX_W-1:0] owner_thread;
        logic             handed_off;
    } lock_reply_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [LIST_W-1:0] cfg_wr_data;

    rrhl_req_if req_ch ();
    rrhl_rsp_if rsp_ch ();

    round_robin_handoff_lock u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns period: 4 ns low, then 4 ns high.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The predictor's copy of the lock state. It has the same widths as the
    // block: a 6-bit owner index, a 7-bit active count and one waiting flag
    // per thread slot.
    logic [LIST_W-1:0]      lk_list_size = LIST_SIZE_RESET;
    logic [IDX_W-1:0]       lk_owner     = '0;
    logic                   lk_held      = 1'b0;
    logic [CNT_W-1:0]       lk_active    = '0;
    logic [MAX_THREADS-1:0] lk_wait_flags = '0;

    // Replies that accepted request beats still owe, oldest first.
    lock_reply_t pending_replies[$];

    // Percentages of cycles in which each side holds back. The test sequence
    // changes them from phase to phase.
    int src_idle_pct = 15;
    int rsp_idle_pct = 58;
    // A request for a long receiver hold-off. The receiver process takes it over.
    int rsp_hold_req = 0;

    int fail_count      = 0;
    int beats_sent      = 0;
    int replies_checked = 0;
    int handoffs_seen   = 0;
    int sizes_written   = 0;
    int status_seen[8];

    // Every mismatch goes through this task. It prints one line and counts the
    // failure. Printing stops after a cap so that a broken block cannot flood
    // the log, but counting goes on.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("MISMATCH at reply %0d, %s: got %0d, want %0d (t=%0t)",
                     replies_checked, what, got, want, $realtime);
    endtask

    // This function works out the reply to one accepted request and advances
    // the lock state.
    // - Lock and trylock are refused when the id is not below the usable list
    //   size. The list size is capped at the thread count, and a size of zero
    //   refuses everything.
    // - A lock that is not refused raises its waiting flag. A trylock never
    //   raises one.
    // - Lock and trylock both stretch the active count to cover the id.
    // - An owner that asks again is simply granted again. There is no nesting.
    // - An unlock by the owner clears its own flag. It then scans the next slots
    //   in turn, modulo the active count. The first flagged slot found becomes
    //   the new owner.
    // - Any other unlock, and the spare opcode, change nothing.
    function automatic lock_reply_t predict_reply(input logic [OP_W-1:0] op,
                                                  input logic [ID_W-1:0] id);
        lock_reply_t r;
        int slots;
        int span;
        int me;
        int cand;
        r = '0;
        r.status = ST_NOT_OWNER;
        slots = (int'(lk_list_size) > MAX_THREADS) ? MAX_THREADS : int'(lk_list_size);
        if (op == OP_LOCK || op == OP_TRYLOCK)
        begin
            if (int'(id) >= slots)
                r.status = ST_RANGE;
            else
            begin
                if (int'(lk_active) < int'(id) + 1)
                    lk_active = CNT_W'(int'(id) + 1);
                if (op == OP_LOCK)
                    lk_wait_flags[id] = 1'b1;
                if (!lk_held)
                begin
                    lk_held  = 1'b1;
                    lk_owner = IDX_W'(id);
                end
                if (ID_W'(lk_owner) == id)
                    r.status = ST_GRANTED;
                else
                    r.status = (op == OP_LOCK) ? ST_WAITING : ST_BUSY;
            end
        end
        else if (op == OP_UNLOCK && lk_held && ID_W'(lk_owner) == id)
        begin
            span = int'(lk_active);
            me   = int'(lk_owner);
            lk_wait_flags[me] = 1'b0;
            lk_held  = 1'b0;
            lk_owner = '0;
            for (int i = 1; i < span && !r.handed_off; i++)
            begin
                cand = (i + me) % span;
                if (lk_wait_flags[cand])
                begin
                    lk_held      = 1'b1;
                    lk_owner     = IDX_W'(cand);
                    r.handed_off = 1'b1;
                end
            end
            r.status = ST_RELEASED;
        end
        r.owner_valid  = lk_held;
        r.owner_thread = lk_held ? lk_owner : '0;
        return r;
    endfunction

    // This task sends one request beat. It is entered at a falling edge and
    // leaves at one. Valid stays high from one beat to the next unless the
    // sender idles first. That way valid gets at most one update per time step.
    // The reply is predicted at the rising edge that accepts the beat.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        int gap;
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.thread_id <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_replies.push_back(predict_reply(op, id));
        beats_sent++;
        @(negedge clk);
    endtask

    // This task builds one request from the predictor's view of the lock, so
    // that most traffic is well formed.
    // - Most unlocks come from the current owner.
    // - Most ids fall inside the usable list.
    // - The rest are stray unlocks, out-of-range ids that reach every bit of the
    //   id field, and the spare opcode.
    task automatic send_random_beat();
        int slots;
        int roll;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        slots = (int'(lk_list_size) > MAX_THREADS) ? MAX_THREADS : int'(lk_list_size);
        roll = $urandom_range(99);
        if (roll < 40)
            op = OP_LOCK;
        else if (roll < 52)
            op = OP_TRYLOCK;
        else if (roll < 94)
            op = OP_UNLOCK;
        else
            op = OP_SPARE;
        roll = $urandom_range(99);
        if (op == OP_UNLOCK && lk_held && roll < 75)
            id = ID_W'(lk_owner);
        else if (slots > 0 && roll < 92)
            id = ID_W'($urandom_range(slots - 1));
        else
            id = ID_W'($urandom_range(255));
        send_beat(op, id);
    endtask

    // This task stops offering beats and waits until every reply owed has come
    // back. It then waits on so that the block is truly idle.
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // This task writes the list size register. It first lets the block go idle,
    // because the register may only change while no request is in flight.
    task automatic write_list_size(input logic [LIST_W-1:0] value);
        drain_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        lk_list_size = value;
        sizes_written++;
    endtask

    // The checker compares each accepted reply beat, field by field, with the
    // oldest prediction.
    task automatic check_reply();
        lock_reply_t want;
        if (pending_replies.size() == 0)
        begin
            report_mismatch("reply with no request waiting", 8'(rsp_ch.status), 8'd0);
            return;
        end
        want = pending_replies.pop_front();
        replies_checked++;
        if (!$isunknown(rsp_ch.status))
            status_seen[rsp_ch.status]++;
        if (rsp_ch.handed_off === 1'b1)
            handoffs_seen++;
        if (rsp_ch.status !== want.status)
            report_mismatch("status", 8'(rsp_ch.status), 8'(want.status));
        if (rsp_ch.owner_valid !== want.owner_valid)
            report_mismatch("owner_valid", 8'(rsp_ch.owner_valid), 8'(want.owner_valid));
        if (rsp_ch.owner_thread !== want.owner_thread)
            report_mismatch("owner_thread", 8'(rsp_ch.owner_thread), 8'(want.owner_thread));
        if (rsp_ch.handed_off !== want.handed_off)
            report_mismatch("handed_off", 8'(rsp_ch.handed_off), 8'(want.handed_off));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
            check_reply();
    end

    // The receiver drives ready at every falling edge. It stalls at random with
    // the current percentage. When a long hold-off is requested, it takes the
    // request over and counts the held cycles down itself.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_req > 0)
            begin
                hold_left    = rsp_hold_req;
                rsp_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // This test uses the reset list size, so every id below 64 is usable.
    // - It checks the empty lock.
    // - It checks a repeated grant and a blocked lock that later wins by handoff.
    // - It checks a busy trylock and a trylock that leaves no waiting flag.
    // - It checks stray unlocks, including ids far beyond the list.
    // - It checks the spare opcode and the highest usable thread.
    // The active count starts small, so the early scans wrap over only three slots.
    task automatic test_basic_ownership();
        send_beat(OP_UNLOCK,  8'd0);
        send_beat(OP_LOCK,    8'd2);
        send_beat(OP_LOCK,    8'd2);
        send_beat(OP_LOCK,    8'd0);
        send_beat(OP_TRYLOCK, 8'd1);
        send_beat(OP_UNLOCK,  8'd1);
        send_beat(OP_UNLOCK,  8'd2);
        send_beat(OP_LOCK,    8'd2);
        send_beat(OP_UNLOCK,  8'd0);
        send_beat(OP_UNLOCK,  8'd2);
        send_beat(OP_TRYLOCK, 8'd1);
        send_beat(OP_UNLOCK,  8'd1);
        send_beat(OP_LOCK,    8'd64);
        send_beat(OP_TRYLOCK, 8'd255);
        send_beat(OP_UNLOCK,  8'd255);
        send_beat(OP_SPARE,   8'd170);
        send_beat(OP_LOCK,    8'd63);
        send_beat(OP_UNLOCK,  8'd63);
        drain_replies();
    endtask

    // This test checks the list size at its edges.
    // - With zero, every request is refused.
    // - The largest setting acts as the full thread count.
    // - With one, only thread zero is served.
    // - One step above the thread count also acts as the full count.
    task automatic test_list_size_limits();
        write_list_size(7'd0);
        send_beat(OP_LOCK,    8'd0);
        send_beat(OP_TRYLOCK, 8'd0);
        write_list_size(7'd127);
        send_beat(OP_LOCK,    8'd63);
        send_beat(OP_TRYLOCK, 8'd64);
        send_beat(OP_UNLOCK,  8'd63);
        write_list_size(7'd1);
        send_beat(OP_TRYLOCK, 8'd1);
        send_beat(OP_LOCK,    8'd0);
        send_beat(OP_UNLOCK,  8'd0);
        write_list_size(7'd65);
        send_beat(OP_LOCK,    8'd64);
        drain_replies();
    endtask

    // This test holds the receiver off for a long stretch while the sender
    // keeps offering beats. Replies back up in the block until it stops taking
    // requests. Once the receiver lets go, everything must drain in order.
    task automatic test_receiver_holdoff();
        write_list_size(7'd64);
        rsp_hold_req = 300;
        repeat (48) send_random_beat();
        drain_replies();
    endtask

    // This test sends one stretch of random, mostly well-formed traffic under a
    // given list size.
    task automatic test_random_traffic(input logic [LIST_W-1:0] list_size, input int beats);
        write_list_size(list_size);
        repeat (beats) send_random_beat();
        drain_replies();
    endtask

    // This block ends the run if the block stops answering. The limit lies far
    // above the slowest correct run.
    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int waited;
        foreach (status_seen[i])
            status_seen[i] = 0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = LIST_SIZE_RESET;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_LOCK;
        req_ch.thread_id = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: the sender idles now and then, and the receiver idles often.
        src_idle_pct = 15;
        rsp_idle_pct = 58;
        test_basic_ownership();
        test_list_size_limits();
        test_random_traffic(7'd64, 325);
        test_random_traffic(7'd6, 325);

        // Phase two: the sender idles often, and the receiver idles now and then.
        src_idle_pct = 58;
        rsp_idle_pct = 15;
        test_random_traffic(7'd127, 325);
        test_random_traffic(7'd2, 325);

        // Phase three: neither side idles, apart from the long receiver hold-off.
        src_idle_pct = 0;
        rsp_idle_pct = 0;
        test_receiver_holdoff();
        test_random_traffic(7'd33, 325);
        test_random_traffic(7'd64, 325);

        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_replies.size() != 0)
            report_mismatch("replies never delivered", 8'(pending_replies.size()), 8'd0);

        $display("Covered %0d request beats, %0d replies, %0d handoffs, %0d list size writes.",
                 beats_sent, replies_checked, handoffs_seen, sizes_written);
        $display("Replies: granted %0d, waiting %0d, busy %0d, range %0d, not owner %0d, released %0d.",
                 status_seen[ST_GRANTED], status_seen[ST_WAITING], status_seen[ST_BUSY],
                 status_seen[ST_RANGE], status_seen[ST_NOT_OWNER], status_seen[ST_RELEASED]);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
